FILE: rtl/core/prls_pkg.sv
// ----------------------------------------------------------------------------
// prls_pkg
// Shared types, codes and helpers of the priority ready-list scheduler.
// ----------------------------------------------------------------------------
package prls_pkg;

  localparam int DefNumTasks  = 16;
  localparam int DefNumLevels = 16;

  localparam int IdW     = 4;   // task id field on the ports
  localparam int FieldW  = 4;   // level field per task in the priority registers
  localparam int CfgW    = 32;
  localparam int WideIdW = 6;   // wide enough for any task index

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_WAKE   = 2'd0;
  localparam opcode_t OP_IDLE   = 2'd1;
  localparam opcode_t OP_SWITCH = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_NOT_READY  = 2'd1;
  localparam status_t STATUS_EMPTY_LIST = 2'd2;

  localparam logic CFG_PRIO_LO = 1'b0;
  localparam logic CFG_PRIO_HI = 1'b1;

  // raw level field of a task, zero for tasks beyond the two registers
  function automatic logic [FieldW-1:0] level_field(input logic [CfgW-1:0]    prio_lo,
                                                    input logic [CfgW-1:0]    prio_hi,
                                                    input logic [WideIdW-1:0] tsk);
    logic [FieldW-1:0] res;
    res = '0;
    if (tsk < WideIdW'(8)) begin
      res = prio_lo[tsk[2:0]*FieldW +: FieldW];
    end else if (tsk < WideIdW'(16)) begin
      res = prio_hi[tsk[2:0]*FieldW +: FieldW];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/prls_ram.sv
// ----------------------------------------------------------------------------
// prls_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module prls_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/priority_ready_list_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_list_scheduler
// Ready-list scheduler: one circular doubly linked ring of tasks per level.
// ----------------------------------------------------------------------------
// Each operation (wake, idle, switch) returns one result. The ring links, the
// level heads and each task's latched level live in small RAMs with a single
// write and a registered read port, and a sequencer walks an operation through
// them step by step, so the input is stalled until the result is loaded. A
// switch, a rejected idle, an undefined opcode or a wake of a ready task go
// straight to the final step. A wake onto an empty level writes the head and
// a ring of one; onto a non-empty level it reads the head, then the head's
// next task, then links in and closes the ring. An idle reads the task's
// links and latched level, unlinks it and moves the head on if it was the
// head. The next item is taken from the cycle after the load, while the
// result still waits for its transfer, but a result is not loaded until the
// previous one has gone. The RAM contents need no clearing after reset.
module priority_ready_list_scheduler
  import prls_pkg::*;
#(
  parameter int NUM_TASKS  = DefNumTasks,
  parameter int NUM_LEVELS = DefNumLevels
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      opcode,
  input  logic [IdW-1:0]  task_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IdW-1:0]  head_task,
  output logic            any_ready,
  output logic            preempt,
  output logic [IdW-1:0]  running_task,
  output logic [1:0]      status
);

  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_W_HEAD  = 4'd1;
  localparam logic [3:0] ST_W_NEXT  = 4'd2;
  localparam logic [3:0] ST_W_LINK  = 4'd3;
  localparam logic [3:0] ST_W_CLOSE = 4'd4;
  localparam logic [3:0] ST_I_READ  = 4'd5;
  localparam logic [3:0] ST_I_LINK  = 4'd6;
  localparam logic [3:0] ST_I_HEAD  = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;
  localparam logic [3:0] ST_RESP    = 4'd9;

  logic [3:0]            state;
  logic [CfgW-1:0]       prio_lo;
  logic [CfgW-1:0]       prio_hi;
  logic [NUM_TASKS-1:0]  ready_bits;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [TW-1:0]         current;
  opcode_t               op_q;
  logic [TW-1:0]         t_q;
  logic [LW-1:0]         lv_q;
  logic                  preempt_q;
  status_t               status_q;
  logic [TW-1:0]         h_q;
  logic [TW-1:0]         n_q;

  // ram ports
  logic          next_we, prev_we, head_we, tl_we;
  logic [TW-1:0] next_waddr, next_wdata, next_raddr, next_rd;
  logic [TW-1:0] prev_waddr, prev_wdata, prev_raddr, prev_rd;
  logic [LW-1:0] head_waddr, head_raddr;
  logic [TW-1:0] head_wdata, head_rd;
  logic [TW-1:0] tl_waddr, tl_raddr;
  logic [LW-1:0] tl_wdata, tl_rd;

  logic            in_xfer;
  logic [TW-1:0]   t_idx;
  logic            t_valid;
  logic [FieldW-1:0] t_field, cur_field;
  logic [LW-1:0]   t_level, cur_level;
  logic [LW-1:0]   top_level;
  logic            any_level;
  logic [3:0]      dec_state;
  status_t         dec_status;
  logic            dec_preempt;
  logic            out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign t_idx    = TW'(task_id);
  assign t_valid  = (32'(task_id) < NUM_TASKS);
  assign out_load = (state == ST_RESP) && (!out_valid || !out_stall);

  assign t_field   = level_field(prio_lo, prio_hi, WideIdW'(task_id));
  assign cur_field = level_field(prio_lo, prio_hi, WideIdW'(current));
  assign t_level   = (32'(t_field) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(t_field);
  assign cur_level = (32'(cur_field) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(cur_field);

  // highest non-empty level
  always_comb begin
    top_level = '0;
    any_level = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i]) begin
        top_level = LW'(i);
        any_level = 1'b1;
      end
    end
  end

  // first step of an operation and the result fields known at its transfer
  always_comb begin
    dec_state   = ST_FIN;
    dec_status  = STATUS_OK;
    dec_preempt = 1'b0;
    case (opcode)
      OP_WAKE: begin
        if (t_valid) begin
          dec_preempt = (t_level > cur_level);
          if (!ready_bits[t_idx]) begin
            dec_state = ST_W_HEAD;
          end
        end
      end
      OP_IDLE: begin
        if (t_valid && ready_bits[t_idx]) begin
          dec_state = ST_I_READ;
        end else begin
          dec_status = STATUS_NOT_READY;
        end
      end
      OP_SWITCH: begin
        if (!any_level) begin
          dec_status = STATUS_EMPTY_LIST;
        end
      end
      default: begin
      end
    endcase
  end

  // ram access per sequencer step
  always_comb begin
    next_we    = 1'b0;
    next_waddr = t_q;
    next_wdata = t_q;
    next_raddr = t_q;
    prev_we    = 1'b0;
    prev_waddr = t_q;
    prev_wdata = t_q;
    prev_raddr = t_q;
    head_we    = 1'b0;
    head_waddr = lv_q;
    head_wdata = t_q;
    head_raddr = top_level;
    tl_we      = 1'b0;
    tl_waddr   = t_q;
    tl_wdata   = lv_q;
    tl_raddr   = t_q;
    case (state)
      ST_W_HEAD: begin
        tl_we      = 1'b1;
        head_raddr = lv_q;
        if (!nonempty[lv_q]) begin
          // level starts with this task alone on its ring
          head_we = 1'b1;
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end
      ST_W_NEXT: begin
        next_raddr = head_rd;
      end
      ST_W_LINK: begin
        next_we    = 1'b1;
        next_wdata = next_rd;
        prev_we    = 1'b1;
        prev_wdata = h_q;
      end
      ST_W_CLOSE: begin
        next_we    = 1'b1;
        next_waddr = h_q;
        prev_we    = 1'b1;
        prev_waddr = n_q;
      end
      ST_I_LINK: begin
        head_raddr = tl_rd;
        if (next_rd != t_q) begin
          prev_we    = 1'b1;
          prev_waddr = next_rd;
          prev_wdata = prev_rd;
          next_we    = 1'b1;
          next_waddr = prev_rd;
          next_wdata = next_rd;
        end
      end
      ST_I_HEAD: begin
        if (head_rd == t_q) begin
          head_we    = 1'b1;
          head_wdata = n_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prio_lo    <= '0;
      prio_hi    <= '0;
      ready_bits <= '0;
      nonempty   <= '0;
      current    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PRIO_LO: prio_lo <= cfg_data;
          CFG_PRIO_HI: prio_hi <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            op_q      <= opcode;
            t_q       <= t_idx;
            lv_q      <= t_level;
            preempt_q <= dec_preempt;
            status_q  <= dec_status;
            state     <= dec_state;
          end
        end
        ST_W_HEAD: begin
          if (!nonempty[lv_q]) begin
            nonempty[lv_q] <= 1'b1;
            ready_bits[t_q] <= 1'b1;
            state <= ST_FIN;
          end else begin
            state <= ST_W_NEXT;
          end
        end
        ST_W_NEXT: begin
          h_q   <= head_rd;
          state <= ST_W_LINK;
        end
        ST_W_LINK: begin
          n_q   <= next_rd;
          state <= ST_W_CLOSE;
        end
        ST_W_CLOSE: begin
          ready_bits[t_q] <= 1'b1;
          state <= ST_FIN;
        end
        ST_I_READ: begin
          state <= ST_I_LINK;
        end
        ST_I_LINK: begin
          lv_q <= tl_rd;
          n_q  <= next_rd;
          if (next_rd != t_q) begin
            state <= ST_I_HEAD;
          end else begin
            // last task on its ring
            nonempty[tl_rd] <= 1'b0;
            ready_bits[t_q] <= 1'b0;
            state <= ST_FIN;
          end
        end
        ST_I_HEAD: begin
          ready_bits[t_q] <= 1'b0;
          state <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (out_load) begin
            head_task <= any_level ? IdW'(head_rd) : '0;
            any_ready <= |ready_bits;
            preempt   <= preempt_q;
            status    <= status_q;
            if (op_q == OP_SWITCH && any_level) begin
              current      <= head_rd;
              running_task <= IdW'(head_rd);
            end else begin
              running_task <= IdW'(current);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  prls_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rd)
  );

  prls_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rd)
  );

  prls_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rd)
  );

  // level latched per task at wake
  prls_ram #(.WIDTH(LW), .DEPTH(NUM_TASKS)) u_level_ram (
    .clk   (clk),
    .we    (tl_we),
    .waddr (tl_waddr),
    .wdata (tl_wdata),
    .raddr (tl_raddr),
    .rdata (tl_rd)
  );

endmodule

FILE: dv/prls_checker.sv
// ----------------------------------------------------------------------------
// prls_checker
// Watches the scheduler's ports, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Keeps its own copy of the per-level rings, the level registers and the
// current task. Each input transfer queues one predicted result. Each output
// transfer is checked field by field against the oldest prediction.
module prls_checker
  import prls_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  input  logic            in_stall,
  input  opcode_t         opcode,
  input  logic [IdW-1:0]  task_id,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [IdW-1:0]  head_task,
  input  logic            any_ready,
  input  logic            preempt,
  input  logic [IdW-1:0]  running_task,
  input  status_t         status,
  output int              pending,
  output int              mismatches,
  output int              results_checked
);

  typedef struct packed {
    logic [IdW-1:0] head;
    logic           any;
    logic           pre;
    logic [IdW-1:0] run;
    status_t        st;
  } sched_result_t;

  logic [CfgW-1:0]         prio_lo;
  logic [CfgW-1:0]         prio_hi;
  logic [IdW-1:0]          ring_fwd    [DefNumTasks];
  logic [IdW-1:0]          ring_back   [DefNumTasks];
  logic [IdW-1:0]          level_first [DefNumLevels];
  logic [FieldW-1:0]       wake_level  [DefNumTasks];
  logic [DefNumLevels-1:0] level_busy;
  logic [DefNumTasks-1:0]  ready_set;
  logic [IdW-1:0]          cur_task;
  sched_result_t           due_results [$];
  int                      n_bad;
  int                      n_seen;

  initial begin
    n_bad  = 0;
    n_seen = 0;
  end

  // level taken from the live registers
  function automatic logic [FieldW-1:0] task_prio(input logic [IdW-1:0] t);
    logic [CfgW-1:0] word;
    word = t[3] ? prio_hi : prio_lo;
    return FieldW'(word >> (FieldW * t[2:0]));
  endfunction

  function automatic int highest_level();
    for (int l = DefNumLevels - 1; l >= 0; l--) begin
      if (level_busy[l]) return l;
    end
    return -1;
  endfunction

  function automatic sched_result_t schedule_op(input opcode_t op, input logic [IdW-1:0] t);
    sched_result_t     r;
    logic [FieldW-1:0] lv;
    logic [IdW-1:0]    h;
    logic [IdW-1:0]    n;
    logic [IdW-1:0]    p;
    int                top;
    r = '0;
    r.st = STATUS_OK;
    case (op)
      OP_WAKE: begin
        if (!ready_set[t]) begin
          lv = task_prio(t);
          wake_level[t] = lv;
          if (!level_busy[lv]) begin
            level_first[lv] = t;
            ring_fwd[t] = t;
            ring_back[t] = t;
            level_busy[lv] = 1'b1;
          end else begin
            // link in just behind the head
            h = level_first[lv];
            n = ring_fwd[h];
            ring_fwd[t] = n;
            ring_back[t] = h;
            ring_back[n] = t;
            ring_fwd[h] = t;
          end
          ready_set[t] = 1'b1;
        end
        r.pre = task_prio(t) > task_prio(cur_task);
      end
      OP_IDLE: begin
        if (ready_set[t]) begin
          // the level latched at wake, not the live one
          lv = wake_level[t];
          n = ring_fwd[t];
          p = ring_back[t];
          if (n != t) begin
            ring_back[n] = p;
            ring_fwd[p] = n;
            if (level_first[lv] == t) level_first[lv] = n;
          end else begin
            level_busy[lv] = 1'b0;
          end
          ready_set[t] = 1'b0;
        end else begin
          r.st = STATUS_NOT_READY;
        end
      end
      OP_SWITCH: begin
        top = highest_level();
        if (top < 0) r.st = STATUS_EMPTY_LIST;
        else cur_task = level_first[top];
      end
      default: begin
      end
    endcase
    top = highest_level();
    r.head = (top < 0) ? '0 : level_first[top];
    r.any  = |ready_set;
    r.run  = cur_task;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [IdW-1:0] want,
                               input logic [IdW-1:0] got);
    if (want !== got) begin
      if (n_bad < 10) begin
        $display("mismatch on %s in result %0d: expected %0d, got %0d",
                 what, n_seen, want, got);
      end
      n_bad++;
    end
  endtask

  always @(posedge clk) begin : track
    sched_result_t want;
    if (rst) begin
      prio_lo     = '0;
      prio_hi     = '0;
      ring_fwd    = '{default: '0};
      ring_back   = '{default: '0};
      level_first = '{default: '0};
      wake_level  = '{default: '0};
      level_busy  = '0;
      ready_set   = '0;
      cur_task    = '0;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_PRIO_LO) prio_lo = cfg_data;
        else prio_hi = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          if (n_bad < 10) begin
            $display("result %0d with nothing outstanding: head %0d running %0d status %0d",
                     n_seen, head_task, running_task, status);
          end
          n_bad++;
        end else begin
          want = due_results.pop_front();
          compare_field("head_task", want.head, head_task);
          compare_field("any_ready", IdW'(want.any), IdW'(any_ready));
          compare_field("preempt", IdW'(want.pre), IdW'(preempt));
          compare_field("running_task", want.run, running_task);
          compare_field("status", IdW'(want.st), IdW'(status));
        end
        n_seen++;
      end
      // output side first: a result never leaves in its own input's cycle
      if (in_valid && !in_stall) due_results.push_back(schedule_op(opcode, task_id));
    end
    pending         <= due_results.size();
    mismatches      <= n_bad;
    results_checked <= n_seen;
  end

endmodule

FILE: dv/priority_ready_list_scheduler_tb.sv
// ----------------------------------------------------------------------------
// priority_ready_list_scheduler_tb
// Directed and random scheduler operations under several level settings.
// ----------------------------------------------------------------------------
// A short directed sequence walks the empty list, rejected idles, undefined
// opcodes, preemption and head movement on a shared ring, and a level change
// while tasks are ready. Random phases follow, each under its own level
// registers, with random gaps on the input and random stalls on the output.
// All checking is done by prls_checker.
module priority_ready_list_scheduler_tb
  import prls_pkg::*;
();

  localparam opcode_t OP_UNUSED      = 2'd3;
  localparam int      WATCHDOG_LIMIT = 4000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = CFG_PRIO_LO;
  logic [CfgW-1:0]  cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  opcode_t          opcode    = OP_WAKE;
  logic [IdW-1:0]   task_id   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IdW-1:0]   head_task;
  logic             any_ready;
  logic             preempt;
  logic [IdW-1:0]   running_task;
  status_t          status;
  int               pending;
  int               mismatches;
  int               results_checked;

  logic [DefNumTasks-1:0] woken       = '0;
  logic                   steady      = 1'b0;
  logic                   sink_steady = 1'b0;
  int                     stall_hold  = 0;
  int                     quiet_cycles = 0;
  int                     n_wake, n_idle, n_switch, n_unused, n_settings;

  priority_ready_list_scheduler u_dut (.*);

  prls_checker u_checker (.*);

  always #6 clk = ~clk;

  // output stall pattern: short bursts mostly, now and then a long hold
  always @(posedge clk) begin : sink_stall
    int r;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(99);
      if (sink_steady) begin
        out_stall <= 1'b0;
      end else if (r < 60) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(3);
      end else if (r < 92) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(30, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("** priority_ready_list_scheduler: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // only a few distinct levels, so rings get shared
  function automatic logic [CfgW-1:0] coarse_levels();
    logic [CfgW-1:0] w;
    w = '0;
    for (int k = 0; k < CfgW / FieldW; k++) begin
      w[k*FieldW +: FieldW] = FieldW'(5 * $urandom_range(3));
    end
    return w;
  endfunction

  task automatic send_op(input opcode_t op, input logic [IdW-1:0] id);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    task_id  <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      OP_WAKE: begin
        n_wake++;
        woken[id] = 1'b1;
      end
      OP_IDLE: begin
        n_idle++;
        woken[id] = 1'b0;
      end
      OP_SWITCH: n_switch++;
      default:   n_unused++;
    endcase
  endtask

  // hold the input until every outstanding result has made its transfer
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_levels(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRIO_LO;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_PRIO_HI;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input int items, input int wake_pct);
    opcode_t        op;
    logic [IdW-1:0] id;
    int             r;
    for (int k = 0; k < items; k++) begin
      if (k % 25 == 0) begin
        steady      = ($urandom_range(3) == 0);
        sink_steady <= ($urandom_range(3) == 0);
      end
      if ($urandom_range(59) == 0) drain();
      r  = $urandom_range(99);
      id = IdW'($urandom_range(DefNumTasks - 1));
      if (r < wake_pct) begin
        op = OP_WAKE;
      end else if (r < wake_pct + 30) begin
        op = OP_IDLE;
        // mostly idle a task that is actually on a ring
        if (woken != '0 && $urandom_range(4) != 0) begin
          while (!woken[id]) id = IdW'($urandom_range(DefNumTasks - 1));
        end
      end else if (r < 97) begin
        op = OP_SWITCH;
      end else begin
        op = OP_UNUSED;
      end
      send_op(op, id);
    end
    drain();
  endtask

  initial begin : stimulus
    n_wake     = 0;
    n_idle     = 0;
    n_switch   = 0;
    n_unused   = 0;
    n_settings = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // task t sits on level t
    set_levels(32'h7654_3210, 32'hFEDC_BA98);
    send_op(OP_SWITCH, 4'd0);
    send_op(OP_IDLE, 4'd3);
    send_op(OP_UNUSED, 4'd15);
    send_op(OP_WAKE, 4'd0);
    send_op(OP_WAKE, 4'd15);
    send_op(OP_WAKE, 4'd15);
    send_op(OP_SWITCH, 4'd9);
    send_op(OP_WAKE, 4'd7);
    send_op(OP_IDLE, 4'd15);
    send_op(OP_SWITCH, 4'd0);
    send_op(OP_IDLE, 4'd7);
    send_op(OP_IDLE, 4'd0);
    send_op(OP_SWITCH, 4'd0);
    drain();

    // one shared ring: head idle, middle idle, last task out
    set_levels('0, '0);
    send_op(OP_WAKE, 4'd1);
    send_op(OP_WAKE, 4'd2);
    send_op(OP_WAKE, 4'd3);
    send_op(OP_WAKE, 4'd4);
    send_op(OP_IDLE, 4'd1);
    send_op(OP_SWITCH, 4'd0);
    send_op(OP_IDLE, 4'd3);
    send_op(OP_WAKE, 4'd9);
    send_op(OP_IDLE, 4'd4);
    send_op(OP_IDLE, 4'd9);
    send_op(OP_IDLE, 4'd2);
    send_op(OP_WAKE, 4'd5);
    drain();

    // levels change under a ready task: its idle must use the old level
    set_levels('1, '0);
    send_op(OP_IDLE, 4'd5);
    send_op(OP_WAKE, 4'd5);
    send_op(OP_WAKE, 4'd12);
    send_op(OP_SWITCH, 4'd0);
    drain();

    set_levels($urandom, $urandom);
    run_phase(75, 40);
    set_levels(coarse_levels(), coarse_levels());
    run_phase(75, 45);
    set_levels('0, '0);
    run_phase(75, 35);
    set_levels('1, '1);
    run_phase(75, 50);
    set_levels(coarse_levels(), $urandom);
    run_phase(75, 30);
    set_levels($urandom, coarse_levels());
    run_phase(75, 40);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d operations: %0d wake, %0d idle, %0d switch, %0d undefined opcode",
             n_wake + n_idle + n_switch + n_unused, n_wake, n_idle, n_switch, n_unused);
    $display("under %0d level settings, %0d results checked, %0d mismatches",
             n_settings, results_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("** priority_ready_list_scheduler: PASSED **");
    end else begin
      $display("** priority_ready_list_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/prls_pkg.sv
rtl/core/prls_ram.sv
rtl/core/priority_ready_list_scheduler.sv
dv/prls_checker.sv
dv/priority_ready_list_scheduler_tb.sv
